// ===== rtl/core/slt_pkg.sv =====
// ----------------------------------------------------------------------------
// slt_pkg: shared types and constants for the sorted list table
// Operation and status codes, field widths and the command bundle that the
// top level broadcasts to every slot cell.
// ----------------------------------------------------------------------------
`default_nettype none

package slt_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int VALUE_W      = 32;
    localparam int INDEX_W      = 4;
    localparam int COUNT_W      = 5;
    localparam int STATUS_W     = 2;
    localparam int OPCODE_W     = 2;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    typedef enum logic [OPCODE_W-1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef struct packed {
        logic                      en;
        op_t                       op;
        logic signed [VALUE_W-1:0] value;
        logic [INDEX_W-1:0]        index;
    } cell_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/slt_cell.sv =====
// ----------------------------------------------------------------------------
// slt_cell: one slot of the sorted list table
// Holds one element and its occupied flag. On each command it keeps its value,
// takes the new value, or takes its left or right neighbor's value, using a
// one-bit flag passed along the row that marks an earlier insert or match.
// ----------------------------------------------------------------------------
`default_nettype none

module slt_cell #(
    parameter int Pos = 0
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  slt_pkg::cell_cmd_t                  cmd,
    input  wire signed [slt_pkg::VALUE_W-1:0]   left_data,
    input  wire                                 left_valid,
    input  wire signed [slt_pkg::VALUE_W-1:0]   right_data,
    input  wire                                 right_valid,
    input  wire                                 prior_in,
    output logic                                prior_out,
    output logic signed [slt_pkg::VALUE_W-1:0]  data_out,
    output logic                                valid_out,
    output logic [slt_pkg::VALUE_W-1:0]         rd_out,
    output logic                                hit_out
);

    localparam bit Addressable = (Pos < (1 << slt_pkg::INDEX_W));

    logic signed [slt_pkg::VALUE_W-1:0] data_reg, data_next;
    logic                               valid_reg, valid_next;
    logic                               ins_flag;
    logic                               del_match;
    logic                               stop_here;

    // The head slot takes a new value when it is empty or the value is strictly
    // smaller; later slots stop the search at the first empty slot or element not below it.
    always_comb begin
        if (Pos == 0) begin
            ins_flag = !valid_reg || (cmd.value < data_reg);
        end else begin
            ins_flag = !valid_reg || !(cmd.value > data_reg);
        end
        del_match = valid_reg && (data_reg == cmd.value);
    end

    always_comb begin
        unique case (cmd.op)
            slt_pkg::OP_INSERT: stop_here = ins_flag;
            slt_pkg::OP_DELETE: stop_here = del_match;
            default:            stop_here = 1'b0;
        endcase
    end

    assign prior_out = prior_in || stop_here;

    always_comb begin
        data_next  = data_reg;
        valid_next = valid_reg;
        if (cmd.en) begin
            unique case (cmd.op)
                slt_pkg::OP_APPEND: begin
                    if (!valid_reg && left_valid) begin
                        data_next  = cmd.value;
                        valid_next = 1'b1;
                    end
                end
                slt_pkg::OP_INSERT: begin
                    if (prior_in) begin
                        data_next  = left_data;
                        valid_next = left_valid;
                    end else if (ins_flag) begin
                        data_next  = cmd.value;
                        valid_next = 1'b1;
                    end
                end
                slt_pkg::OP_DELETE: begin
                    if (prior_in || del_match) begin
                        data_next  = right_data;
                        valid_next = right_valid;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_comb begin
        hit_out = Addressable && valid_reg
                  && (cmd.index == slt_pkg::INDEX_W'(Pos));
        rd_out  = hit_out ? data_reg : '0;
    end

    assign data_out  = data_reg;
    assign valid_out = valid_reg;

endmodule

`default_nettype wire

// ===== rtl/core/sorted_list_table_top.sv =====
// A result item passes from the command register into the result register.
// Throughput: one item per cycle while the result side does not stall; the whole
// slot row updates together, so the next item sees the new contents at once.
// Back pressure on the result side stalls the command register, then input.
// Reset clears the element count and every slot's occupied flag; slot data
// is not reset.
// ----------------------------------------------------------------------------
// sorted_list_table_top: bounded ordered list in a row of slot cells
// Append, sorted insert, delete-first-match and indexed read, each giving one
// result with status, element count and read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_table_top #(
    parameter int CAPACITY = slt_pkg::CAPACITY_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // [1:0] opcode, [33:2] value, [37:34] index, [39:38] zero
    input  wire [slt_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // [1:0] status, [6:2] count, [38:7] read_value, [39] zero
    output logic [slt_pkg::M_TDATA_W-1:0]    m_tdata
);

    localparam int CntW = $clog2(CAPACITY + 1);

    logic                             cmd_valid_reg;
    slt_pkg::op_t                     cmd_op_reg;
    logic signed [slt_pkg::VALUE_W-1:0] cmd_value_reg;
    logic [slt_pkg::INDEX_W-1:0]      cmd_index_reg;
    logic [CntW-1:0]                  count_reg, count_next;

    logic                             m_valid_reg;
    slt_pkg::status_t                 m_status_reg, status_next;
    logic [slt_pkg::COUNT_W-1:0]      m_count_reg;
    logic [slt_pkg::VALUE_W-1:0]      m_rdata_reg, rdata_next;

    logic                             process;
    logic                             full;
    slt_pkg::cell_cmd_t               cmd;

    logic signed [slt_pkg::VALUE_W-1:0] cell_data  [CAPACITY];
    logic                               cell_valid [CAPACITY];
    logic [slt_pkg::VALUE_W-1:0]        cell_rd    [CAPACITY];
    logic [CAPACITY-1:0]                cell_hit;
    logic [CAPACITY:0]                  chain;

    logic [slt_pkg::VALUE_W-1:0]        rd_or;
    logic [CntW+slt_pkg::COUNT_W-1:0]   count_wide;

    assign process  = cmd_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !cmd_valid_reg || process;
    assign full     = (count_reg == CntW'(CAPACITY));

    always_comb begin
        cmd.op    = cmd_op_reg;
        cmd.value = cmd_value_reg;
        cmd.index = cmd_index_reg;
        unique case (cmd_op_reg)
            slt_pkg::OP_APPEND,
            slt_pkg::OP_INSERT: cmd.en = process && !full;
            slt_pkg::OP_DELETE: cmd.en = process;
            default:            cmd.en = 1'b0;
        endcase
    end

    assign chain[0] = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [slt_pkg::VALUE_W-1:0] l_data, r_data;
        logic                               l_valid, r_valid;

        if (i == 0) begin : g_head
            assign l_data  = cmd_value_reg;
            assign l_valid = 1'b1;
        end else begin : g_body
            assign l_data  = cell_data[i-1];
            assign l_valid = cell_valid[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign r_data  = '0;
            assign r_valid = 1'b0;
        end else begin : g_inner
            assign r_data  = cell_data[i+1];
            assign r_valid = cell_valid[i+1];
        end

        slt_cell #(
            .Pos(i)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd        (cmd),
            .left_data  (l_data),
            .left_valid (l_valid),
            .right_data (r_data),
            .right_valid(r_valid),
            .prior_in   (chain[i]),
            .prior_out  (chain[i+1]),
            .data_out   (cell_data[i]),
            .valid_out  (cell_valid[i]),
            .rd_out     (cell_rd[i]),
            .hit_out    (cell_hit[i])
        );
    end

    always_comb begin
        rd_or = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            rd_or = rd_or | cell_rd[i];
        end
    end

    always_comb begin
        count_next  = count_reg;
        status_next = slt_pkg::ST_OK;
        rdata_next  = '0;
        unique case (cmd_op_reg)
            slt_pkg::OP_APPEND,
            slt_pkg::OP_INSERT: begin
                if (full) begin
                    status_next = slt_pkg::ST_FULL;
                end else begin
                    count_next = count_reg + CntW'(1);
                end
            end
            slt_pkg::OP_DELETE: begin
                if (chain[CAPACITY]) begin
                    count_next = count_reg - CntW'(1);
                end else begin
                    status_next = slt_pkg::ST_MISS;
                end
            end
            default: begin
                if (|cell_hit) begin
                    rdata_next = rd_or;
                end else begin
                    status_next = slt_pkg::ST_MISS;
                end
            end
        endcase
    end

    // The count field carries only the low five bits of the element count.
    assign count_wide = {{slt_pkg::COUNT_W{1'b0}}, count_next};

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cmd_op_reg    <= slt_pkg::op_t'(s_tdata[1:0]);
            cmd_value_reg <= s_tdata[33:2];
            cmd_index_reg <= s_tdata[37:34];
        end
        if (process) begin
            m_status_reg <= status_next;
            m_count_reg  <= count_wide[slt_pkg::COUNT_W-1:0];
            m_rdata_reg  <= rdata_next;
        end
        if (!aresetn) begin
            cmd_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            count_reg     <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                cmd_valid_reg <= 1'b1;
            end else if (process) begin
                cmd_valid_reg <= 1'b0;
            end
            if (process) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (process) begin
                count_reg <= count_next;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_rdata_reg, m_count_reg, m_status_reg};

endmodule

`default_nettype wire

// ===== rtl/core/slt_checker.sv =====
// ----------------------------------------------------------------------------
// slt_checker: port-level checks for the sorted list table
// Watches the result channel of the top level; attached by a bind.
// ----------------------------------------------------------------------------
`default_nettype none

module slt_checker #(
    parameter int Capacity = slt_pkg::CAPACITY_DEF
) (
    input wire                            aclk,
    input wire                            aresetn,
    input wire                            m_tvalid,
    input wire                            m_tready,
    input wire [slt_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam logic [slt_pkg::COUNT_W-1:0] CapMasked = slt_pkg::COUNT_W'(Capacity);

    // A stalled result item must stay offered.
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result item dropped while stalled");

    // The status code is never the unused code.
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] == slt_pkg::ST_OK)
                  || (m_tdata[1:0] == slt_pkg::ST_MISS)
                  || (m_tdata[1:0] == slt_pkg::ST_FULL))
        else $error("status outside the defined codes");

    // A full report means the list holds its whole capacity.
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] == slt_pkg::ST_FULL) |-> m_tdata[6:2] == CapMasked)
        else $error("full status with a partial count");

    // Only a successful read returns nonzero data.
    a_read_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] != slt_pkg::ST_OK) |-> m_tdata[38:7] == '0)
        else $error("read data present on a failed item");

endmodule

bind sorted_list_table_top slt_checker #(
    .Capacity(CAPACITY)
) u_slt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

`default_nettype wire
